// ----- src/rtccal_pkg.sv -----
// ----------------------------------------------------------------------------
// rtccal_pkg
// Types, request codes and calendar constants for the RTC calendar block.
// ----------------------------------------------------------------------------
package rtccal_pkg;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_SET_TIME   = 2'd1,
        REQ_LOAD_TIMER = 2'd2,
        REQ_CLEAR_FLAG = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    typedef struct packed {
        logic        tick;
        logic        load;
        logic [7:0]  index;
        logic [15:0] value;
    } tmr_cmd_t;

    localparam logic [11:0] YEAR_RESET   = 12'd2000;
    localparam logic [3:0]  MONTH_RESET  = 4'd1;
    localparam logic [4:0]  DAY_RESET    = 5'd1;
    localparam logic [15:0] STEP_RESET   = 16'd1;

    localparam logic [6:0]  SECOND_MAX   = 7'd59;
    localparam logic [6:0]  MINUTE_MAX   = 7'd59;
    localparam logic [5:0]  HOUR_MAX     = 6'd23;
    localparam logic [4:0]  MONTH_MAX    = 5'd12;
    localparam logic [7:0]  FLAG_BIT_MAX = 8'd7;

    localparam logic [4:0]  DAYS_LONG    = 5'd31;
    localparam logic [4:0]  DAYS_SHORT   = 5'd30;
    localparam logic [4:0]  DAYS_FEB     = 5'd28;
    localparam logic [4:0]  DAYS_FEB_LEAP = 5'd29;

    localparam logic [7:0]  FLAG_SECOND   = 8'h01;
    localparam logic [7:0]  FLAG_MINUTE   = 8'h02;
    localparam logic [7:0]  FLAG_PERIODIC = 8'h04;
    localparam logic [7:0]  FLAG_EVEN_SEC = 8'h08;
    localparam logic [7:0]  FLAG_SECOND_B = 8'h10;
    localparam logic [7:0]  FLAG_MINUTE_B = 8'h20;

    function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                 input logic [1:0] year_low);
        logic [4:0] n;
        case (month)
            4'd2:                      n = (year_low == 2'd0) ? DAYS_FEB_LEAP : DAYS_FEB;
            4'd4, 4'd6, 4'd9, 4'd11:   n = DAYS_SHORT;
            default:                   n = DAYS_LONG;
        endcase
        return n;
    endfunction

endpackage

// ----- src/rtccal_tick_step.sv -----
// ----------------------------------------------------------------------------
// rtccal_tick_step
// One-second calendar advance with second, minute, hour, day, month and
// year carries.
// ----------------------------------------------------------------------------
module rtccal_tick_step (
    input  rtccal_pkg::cal_t cur,
    output rtccal_pkg::cal_t nxt
);

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_step;
    logic [4:0] dim;
    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       day_wrap;
    logic       month_over;

    always_comb
    begin
        sec_inc    = {1'b0, cur.second} + 7'd1;
        min_inc    = {1'b0, cur.minute} + 7'd1;
        hour_inc   = {1'b0, cur.hour} + 6'd1;
        day_inc    = {1'b0, cur.day} + 6'd1;
        dim        = rtccal_pkg::days_in_month(cur.month, cur.year[1:0]);

        sec_wrap   = sec_inc > rtccal_pkg::SECOND_MAX;
        min_wrap   = sec_wrap && (min_inc > rtccal_pkg::MINUTE_MAX);
        hour_wrap  = min_wrap && (hour_inc > rtccal_pkg::HOUR_MAX);
        day_wrap   = day_inc > {1'b0, dim};
        month_step = {1'b0, cur.month} + {4'd0, day_wrap};
        month_over = month_step > rtccal_pkg::MONTH_MAX;

        nxt        = cur;
        nxt.second = sec_wrap ? 6'd0 : sec_inc[5:0];
        if (sec_wrap)
        begin
            nxt.minute = min_wrap ? 6'd0 : min_inc[5:0];
        end
        if (min_wrap)
        begin
            nxt.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
        end
        if (hour_wrap)
        begin
            nxt.day   = day_wrap ? rtccal_pkg::DAY_RESET : day_inc[4:0];
            nxt.month = month_over ? rtccal_pkg::MONTH_RESET : month_step[3:0];
            nxt.year  = month_over ? cur.year + 12'd1 : cur.year;
        end
    end

endmodule

// ----- src/rtccal_timers.sv -----
// ----------------------------------------------------------------------------
// rtccal_timers
// Bank of 16-bit countdown timers with saturating decrement, load and
// read-back of the updated count.
// ----------------------------------------------------------------------------
module rtccal_timers #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtccal_pkg::tmr_cmd_t cmd,
    input  logic [15:0]          step,
    output logic [15:0]          rd_data
);

    logic [15:0] store_reg  [NUM_TIMERS];
    logic [15:0] store_next [NUM_TIMERS];

    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            store_next[i] = store_reg[i];
            if (cmd.tick)
            begin
                store_next[i] = (store_reg[i] >= step) ? store_reg[i] - step : 16'd0;
            end
            if (cmd.load && (cmd.index == 8'(i)))
            begin
                store_next[i] = cmd.value;
            end
        end
    end

    always_comb
    begin
        rd_data = 16'd0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (cmd.index == 8'(i))
            begin
                rd_data = store_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                store_reg[i] <= 16'd0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule

// ----- src/rtc_calendar_tick_with_timers_unit.sv -----
// ----------------------------------------------------------------------------
// rtc_calendar_tick_with_timers_unit
// Real-time clock with binary calendar, countdown timers and event flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: tick, set
//   time, load timer or clear flag bit. Output channel (out_valid /
//   out_stall) returns one word per request: the calendar, the flags and the
//   addressed timer, all as they stand after that request.
//   cfg_wr_en / cfg_wr_data write the timer step; write it while idle.
// Path: a word accepted at a clock edge lands in the input register, is
//   processed from there, and its result is captured in the result register,
//   from which it is presented.
// Throughput: one word per cycle while the result is not stalled; the
//   calendar carry chain and the parallel timer decrements form one short
//   combinational pass between the input register and the result register.
// Reset: calendar 2000-01-01 00:00:00, flags and timers zero, step 1, both
//   pipeline registers empty.
// Stall: a stalled result holds; the input register still takes one more
//   word, after which in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module rtc_calendar_tick_with_timers_unit #(
    parameter int NUM_TIMERS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [11:0] new_year,
    input  logic [3:0]  new_month,
    input  logic [4:0]  new_day,
    input  logic [4:0]  new_hour,
    input  logic [5:0]  new_minute,
    input  logic [5:0]  new_second,
    input  logic [7:0]  timer_index,
    input  logic [15:0] timer_load,
    input  logic [7:0]  flag_bit,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] cur_year,
    output logic [3:0]  cur_month,
    output logic [4:0]  cur_day,
    output logic [4:0]  cur_hour,
    output logic [5:0]  cur_minute,
    output logic [5:0]  cur_second,
    output logic [7:0]  event_flags,
    output logic [15:0] timer_remaining
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    rtccal_pkg::req_type_t req_reg;
    rtccal_pkg::cal_t      set_cal_reg;
    logic [7:0]            index_reg;
    logic [15:0]           load_reg;
    logic [7:0]            flag_bit_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    rtccal_pkg::cal_t      out_cal_reg;
    logic [7:0]            out_flags_reg;
    logic [15:0]           out_timer_reg;

    rtccal_pkg::cal_t      cal_reg;
    rtccal_pkg::cal_t      cal_next;
    rtccal_pkg::cal_t      tick_cal;
    logic [7:0]            flags_reg;
    logic [7:0]            flags_next;
    logic [15:0]           step_reg;

    rtccal_pkg::tmr_cmd_t  tmr_cmd;
    logic [15:0]           tmr_rd_data;

    logic                  in_take;
    logic                  advance;

    assign advance       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall      = in_valid_reg && !advance;
    assign in_take       = in_valid && !in_stall;
    assign in_valid_next = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    rtccal_tick_step u_tick_step (
        .cur (cal_reg),
        .nxt (tick_cal)
    );

    always_comb
    begin
        tmr_cmd.tick  = advance && (req_reg == rtccal_pkg::REQ_TICK);
        tmr_cmd.load  = advance && (req_reg == rtccal_pkg::REQ_LOAD_TIMER);
        tmr_cmd.index = index_reg;
        tmr_cmd.value = load_reg;
    end

    rtccal_timers #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_timers (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tmr_cmd),
        .step    (step_reg),
        .rd_data (tmr_rd_data)
    );

    always_comb
    begin
        cal_next   = cal_reg;
        flags_next = flags_reg;
        case (req_reg)
            rtccal_pkg::REQ_TICK:
            begin
                cal_next   = tick_cal;
                flags_next = flags_reg | rtccal_pkg::FLAG_SECOND
                           | rtccal_pkg::FLAG_PERIODIC | rtccal_pkg::FLAG_SECOND_B;
                if (!tick_cal.second[0])
                begin
                    flags_next = flags_next | rtccal_pkg::FLAG_EVEN_SEC;
                end
                if (tick_cal.minute == 6'd0)
                begin
                    flags_next = flags_next | rtccal_pkg::FLAG_MINUTE
                               | rtccal_pkg::FLAG_MINUTE_B;
                end
            end
            rtccal_pkg::REQ_SET_TIME:
            begin
                cal_next = set_cal_reg;
            end
            rtccal_pkg::REQ_CLEAR_FLAG:
            begin
                if (flag_bit_reg <= rtccal_pkg::FLAG_BIT_MAX)
                begin
                    flags_next = flags_reg & ~(8'd1 << flag_bit_reg[2:0]);
                end
            end
            default:
            begin
                cal_next   = cal_reg;
                flags_next = flags_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= rtccal_pkg::STEP_RESET;
            flags_reg     <= 8'd0;
            cal_reg.year   <= rtccal_pkg::YEAR_RESET;
            cal_reg.month  <= rtccal_pkg::MONTH_RESET;
            cal_reg.day    <= rtccal_pkg::DAY_RESET;
            cal_reg.hour   <= 5'd0;
            cal_reg.minute <= 6'd0;
            cal_reg.second <= 6'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                step_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                cal_reg   <= cal_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg            <= rtccal_pkg::req_type_t'(req_type);
            set_cal_reg.year   <= new_year;
            set_cal_reg.month  <= new_month;
            set_cal_reg.day    <= new_day;
            set_cal_reg.hour   <= new_hour;
            set_cal_reg.minute <= new_minute;
            set_cal_reg.second <= new_second;
            index_reg          <= timer_index;
            load_reg           <= timer_load;
            flag_bit_reg       <= flag_bit;
        end
        if (advance)
        begin
            out_cal_reg   <= cal_next;
            out_flags_reg <= flags_next;
            out_timer_reg <= tmr_rd_data;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cur_year        = out_cal_reg.year;
    assign cur_month       = out_cal_reg.month;
    assign cur_day         = out_cal_reg.day;
    assign cur_hour        = out_cal_reg.hour;
    assign cur_minute      = out_cal_reg.minute;
    assign cur_second      = out_cal_reg.second;
    assign event_flags     = out_flags_reg;
    assign timer_remaining = out_timer_reg;

endmodule

// ----- src/rtccal_checker.sv -----
// ----------------------------------------------------------------------------
// rtccal_checker
// Port-level checks for the RTC calendar block, bound to the top level.
// ----------------------------------------------------------------------------
module rtccal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  cur_second,
    input logic [7:0]  event_flags,
    input logic [15:0] timer_remaining
);

    property p_unused_flags_low;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_flags[7:6] == 2'b00);
    endproperty

    property p_stall_only_when_full;
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall);
    endproperty

    property p_stalled_result_holds;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(cur_second) && $stable(event_flags)
             && $stable(timer_remaining));
    endproperty

    a_unused_flags_low: assert property (p_unused_flags_low)
        else $error("event flag bits 7:6 set");
    a_stall_only_when_full: assert property (p_stall_only_when_full)
        else $error("input stalled while output path free");
    a_stalled_result_holds: assert property (p_stalled_result_holds)
        else $error("stalled result changed");

endmodule

bind rtc_calendar_tick_with_timers_unit rtccal_checker u_rtccal_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cur_second      (cur_second),
    .event_flags     (event_flags),
    .timer_remaining (timer_remaining)
);
